// File: rtl/wpdc_pkg.sv
`timescale 1ns / 1ps

package wpdc_pkg;

   localparam int WINDOW_DEFAULT = 16;
   localparam int MAX_DUR        = 1024;

   localparam int DUR_W      = 16;
   localparam int QUANT_W    = 9;
   localparam int GAIN_W     = 4;
   localparam int CEIL_W     = 20;
   localparam int BAND_W     = 10;
   localparam int CNT_OUT_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [DUR_W-1:0]   DUR_TOP = DUR_W'(MAX_DUR - 1);
   localparam logic [QUANT_W-1:0] Q_ONE   = QUANT_W'(256);
   localparam int                 Q_FRAC  = 8;
   localparam int                 Q_ROUND = 255;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_OFFSET   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTILE_Q8    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_DURATION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DURATION   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DURATION   = 3'd5;

   localparam logic [DUR_W-1:0]   RST_TOKEN_OFFSET   = 16'd0;
   localparam logic [QUANT_W-1:0] RST_QUANTILE_Q8    = 9'd192;
   localparam logic [DUR_W-1:0]   RST_FLOOR_DURATION = 16'd0;
   localparam logic [GAIN_W-1:0]  RST_CEILING_GAIN   = 4'd1;
   localparam logic [DUR_W-1:0]   RST_MIN_DURATION   = 16'd0;
   localparam logic [DUR_W-1:0]   RST_MAX_DURATION   = 16'hFFFF;

   typedef struct packed {
      logic load;
      logic prep;
      logic sweep;
      logic scale;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_done;
   } dp_status_type;

endpackage

// File: rtl/wpdc_ctrl.sv
`timescale 1ns / 1ps

module wpdc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  wpdc_pkg::dp_status_type status,
   output wpdc_pkg::dp_cmd_type    cmd
);
   import wpdc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SWEEP,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      cmd.load  = req_ready_ff && req_valid;
      cmd.prep  = (state_ff == ST_PREP);
      cmd.sweep = (state_ff == ST_SWEEP);
      cmd.scale = (state_ff == ST_SCALE);
      cmd.emit  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff     <= ST_PREP;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_PREP: begin
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               if (status.sweep_done) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (cmd.emit) begin
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/wpdc_dp.sv
`timescale 1ns / 1ps

module wpdc_dp #(
   parameter int WINDOW = wpdc_pkg::WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_cmd,
   input  logic [wpdc_pkg::DUR_W-1:0]          req_duration_token,
   input  logic                                csr_we,
   input  logic [wpdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wpdc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wpdc_pkg::dp_cmd_type                cmd,
   output wpdc_pkg::dp_status_type             status,
   output logic [wpdc_pkg::CEIL_W-1:0]         rsp_ceiling,
   output logic [wpdc_pkg::BAND_W-1:0]         rsp_allowed_low,
   output logic [wpdc_pkg::BAND_W-1:0]         rsp_allowed_high,
   output logic [wpdc_pkg::CNT_OUT_W-1:0]      rsp_window_count
);
   import wpdc_pkg::*;

   localparam int CW = $clog2(WINDOW + 1);
   localparam int SW = $clog2(WINDOW + 2);
   localparam int PW = QUANT_W + CW;

   logic [DUR_W-1:0]   token_offset_ff, token_offset_in;
   logic [QUANT_W-1:0] quantile_ff, quantile_in;
   logic [DUR_W-1:0]   floor_ff, floor_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [DUR_W-1:0]   min_dur_ff, min_dur_in;
   logic [DUR_W-1:0]   max_dur_ff, max_dur_in;

   logic [DUR_W-1:0]   line_ff [WINDOW];
   logic [DUR_W-1:0]   line_in [WINDOW];
   logic [WINDOW-1:0]  held_ff, held_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      target_ff, target_in;
   logic [SW-1:0]      sweep_cnt_ff, sweep_cnt_in;

   logic               a_vld_ff, a_vld_in;
   logic               a_ok_ff, a_ok_in;
   logic [DUR_W-1:0]   a_cand_ff, a_cand_in;
   logic [WINDOW-1:0]  lt_ff, lt_in;
   logic [WINDOW-1:0]  le_ff, le_in;

   logic               b_vld_ff, b_vld_in;
   logic               b_ok_ff, b_ok_in;
   logic [DUR_W-1:0]   b_cand_ff, b_cand_in;
   logic [CW-1:0]      lt_cnt_ff, lt_cnt_in;
   logic [CW-1:0]      le_cnt_ff, le_cnt_in;

   logic [DUR_W-1:0]   pct_ff, pct_in;
   logic [CEIL_W-1:0]  ceil_ff, ceil_in;

   logic [CEIL_W-1:0]    rsp_ceiling_ff, rsp_ceiling_in;
   logic [BAND_W-1:0]    rsp_low_ff, rsp_low_in;
   logic [BAND_W-1:0]    rsp_high_ff, rsp_high_in;
   logic [CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               rotate;
   logic [DUR_W-1:0]   dur;
   logic [QUANT_W-1:0] q_eff;
   logic [PW-1:0]      rank_full;
   logic [CW-1:0]      rank;
   logic [DUR_W-1:0]   recent;
   logic [DUR_W-1:0]   lowest;
   logic [CEIL_W-1:0]  highest;

   function automatic logic [CW-1:0] popcnt(input logic [WINDOW-1:0] v);
      logic [CW-1:0] s;
      s = '0;
      for (int i = 0; i < WINDOW; i++) begin
         s = s + CW'(v[i]);
      end
      return s;
   endfunction

   // configuration writes
   always_comb begin
      token_offset_in = token_offset_ff;
      quantile_in     = quantile_ff;
      floor_in        = floor_ff;
      gain_in         = gain_ff;
      min_dur_in      = min_dur_ff;
      max_dur_in      = max_dur_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOKEN_OFFSET:   token_offset_in = csr_wdata;
            CSR_QUANTILE_Q8:    quantile_in     = csr_wdata[QUANT_W-1:0];
            CSR_FLOOR_DURATION: floor_in        = csr_wdata;
            CSR_CEILING_GAIN:   gain_in         = csr_wdata[GAIN_W-1:0];
            CSR_MIN_DURATION:   min_dur_in      = csr_wdata;
            CSR_MAX_DURATION:   max_dur_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   assign rotate = cmd.sweep && (sweep_cnt_ff < SW'(WINDOW));
   assign dur    = (req_duration_token > token_offset_ff) ?
                   (req_duration_token - token_offset_ff) : '0;

   // window line: newest at slot 0, rotate one slot per cycle while ranking
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         line_in[i] = line_ff[i];
      end
      held_in  = held_ff;
      count_in = count_ff;
      if (cmd.load) begin
         if (req_cmd == CMD_CLEAR) begin
            count_in = '0;
         end else begin
            line_in[0] = dur;
            for (int i = 1; i < WINDOW; i++) begin
               line_in[i] = line_ff[i-1];
            end
            if (count_ff != CW'(WINDOW)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
      if (cmd.prep) begin
         for (int i = 0; i < WINDOW; i++) begin
            held_in[i] = (CW'(i) < count_ff);
         end
      end
      if (rotate) begin
         for (int i = 0; i < WINDOW; i++) begin
            line_in[i] = line_ff[(i + 1) % WINDOW];
            held_in[i] = held_ff[(i + 1) % WINDOW];
         end
      end
   end

   // nearest rank, at least one
   always_comb begin
      q_eff     = (quantile_ff > Q_ONE) ? Q_ONE : quantile_ff;
      rank_full = ((PW'(q_eff) * PW'(count_ff)) + PW'(Q_ROUND)) >> Q_FRAC;
      rank      = rank_full[CW-1:0];
      target_in = target_ff;
      if (cmd.prep) begin
         target_in = (rank == '0) ? CW'(1) : rank;
      end
   end

   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.prep) begin
         sweep_cnt_in = '0;
      end else if (cmd.sweep) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
      end
   end

   assign status.sweep_done = (sweep_cnt_ff == SW'(WINDOW + 1));

   // compare row, count, select
   always_comb begin
      a_vld_in  = rotate;
      a_cand_in = line_ff[0];
      a_ok_in   = held_ff[0];
      for (int i = 0; i < WINDOW; i++) begin
         lt_in[i] = held_ff[i] && (line_ff[i] < line_ff[0]);
         le_in[i] = held_ff[i] && (line_ff[i] <= line_ff[0]);
      end
      b_vld_in  = a_vld_ff;
      b_ok_in   = a_ok_ff;
      b_cand_in = a_cand_ff;
      lt_cnt_in = popcnt(lt_ff);
      le_cnt_in = popcnt(le_ff);
      pct_in    = pct_ff;
      if (cmd.prep) begin
         pct_in = '0;
      end else if (b_vld_ff && b_ok_ff && (lt_cnt_ff < target_ff) &&
                   (target_ff <= le_cnt_ff)) begin
         pct_in = b_cand_ff;
      end
   end

   always_comb begin
      recent  = (pct_ff < floor_ff) ? floor_ff : pct_ff;
      ceil_in = ceil_ff;
      if (cmd.scale) begin
         ceil_in = CEIL_W'(gain_ff) * CEIL_W'(recent);
      end
   end

   // band and result register
   always_comb begin
      lowest  = (min_dur_ff > DUR_TOP) ? DUR_TOP : min_dur_ff;
      highest = (CEIL_W'(max_dur_ff) < ceil_ff) ? CEIL_W'(max_dur_ff) : ceil_ff;
      if (highest < CEIL_W'(lowest)) begin
         highest = CEIL_W'(lowest);
      end
      if (highest > CEIL_W'(DUR_TOP)) begin
         highest = CEIL_W'(DUR_TOP);
      end
      rsp_ceiling_in = rsp_ceiling_ff;
      rsp_low_in     = rsp_low_ff;
      rsp_high_in    = rsp_high_ff;
      rsp_count_in   = rsp_count_ff;
      if (cmd.emit) begin
         rsp_ceiling_in = ceil_ff;
         rsp_low_in     = lowest[BAND_W-1:0];
         rsp_high_in    = highest[BAND_W-1:0];
         rsp_count_in   = CNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_offset_ff <= RST_TOKEN_OFFSET;
         quantile_ff     <= RST_QUANTILE_Q8;
         floor_ff        <= RST_FLOOR_DURATION;
         gain_ff         <= RST_CEILING_GAIN;
         min_dur_ff      <= RST_MIN_DURATION;
         max_dur_ff      <= RST_MAX_DURATION;
         held_ff         <= '0;
         count_ff        <= '0;
         sweep_cnt_ff    <= '0;
         a_vld_ff        <= 1'b0;
         b_vld_ff        <= 1'b0;
      end else begin
         token_offset_ff <= token_offset_in;
         quantile_ff     <= quantile_in;
         floor_ff        <= floor_in;
         gain_ff         <= gain_in;
         min_dur_ff      <= min_dur_in;
         max_dur_ff      <= max_dur_in;
         held_ff         <= held_in;
         count_ff        <= count_in;
         sweep_cnt_ff    <= sweep_cnt_in;
         a_vld_ff        <= a_vld_in;
         b_vld_ff        <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW; i++) begin
         line_ff[i] <= line_in[i];
      end
      target_ff      <= target_in;
      a_ok_ff        <= a_ok_in;
      a_cand_ff      <= a_cand_in;
      lt_ff          <= lt_in;
      le_ff          <= le_in;
      b_ok_ff        <= b_ok_in;
      b_cand_ff      <= b_cand_in;
      lt_cnt_ff      <= lt_cnt_in;
      le_cnt_ff      <= le_cnt_in;
      pct_ff         <= pct_in;
      ceil_ff        <= ceil_in;
      rsp_ceiling_ff <= rsp_ceiling_in;
      rsp_low_ff     <= rsp_low_in;
      rsp_high_ff    <= rsp_high_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_ceiling      = rsp_ceiling_ff;
   assign rsp_allowed_low  = rsp_low_ff;
   assign rsp_allowed_high = rsp_high_ff;
   assign rsp_window_count = rsp_count_ff;

endmodule

// File: rtl/windowed_percentile_duration_ceiling.sv
// Sliding-window percentile duration ceiling. Each req item either appends a
// duration token (offset removed, floored at zero) to a window of the last
// WINDOW durations or clears the window; each item yields exactly one rsp item
// holding the ceiling (gain times the nearest-rank percentile, raised to the
// floor), the clamped allowed duration band and the current window count.
// An item passes through the prep, sweep, scale and emit states from acceptance
// to its result being loaded into the output register; the sweep ranks the
// window by rotating it past one comparator row, one candidate per cycle,
// through a two-stage count pipeline. One item is in work at a time; req_ready
// returns as soon as the result enters the output register, so the next item
// can be taken while that result waits on rsp_ready.
// Configuration registers are written through csr_we/csr_index/csr_wdata by
// the user, only while no item is in work; the block does not enforce this.
`timescale 1ns / 1ps

module windowed_percentile_duration_ceiling #(
   parameter int WINDOW = wpdc_pkg::WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [wpdc_pkg::DUR_W-1:0]      req_duration_token,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [wpdc_pkg::CEIL_W-1:0]     rsp_ceiling,
   output logic [wpdc_pkg::BAND_W-1:0]     rsp_allowed_low,
   output logic [wpdc_pkg::BAND_W-1:0]     rsp_allowed_high,
   output logic [wpdc_pkg::CNT_OUT_W-1:0]  rsp_window_count,
   input  logic                            csr_we,
   input  logic [wpdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wpdc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wpdc_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   wpdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   wpdc_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_duration_token (req_duration_token),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .rsp_ceiling        (rsp_ceiling),
      .rsp_allowed_low    (rsp_allowed_low),
      .rsp_allowed_high   (rsp_allowed_high),
      .rsp_window_count   (rsp_window_count)
   );

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over an untaken item");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.sweep || dp_cmd.scale || dp_cmd.prep) |-> !req_ready)
      else $error("input ready while an item is in work");

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> dp_cmd.prep)
      else $error("accepted item did not start ranking");

   a_band_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_allowed_low <= rsp_allowed_high))
      else $error("allowed band inverted");
`endif

endmodule
